// ===== hdl/eol_pkg.sv =====
`default_nettype none

package eol_pkg;

    localparam int MAX_AXES = 4;
    localparam int SITE_W   = 15;
    localparam int LEX_W    = SITE_W + 1;
    localparam int COORD_W  = 10;

    typedef struct packed {
        logic [SITE_W-1:0] site_index;
        logic [1:0]        direction;
        logic              backward;
    } request_t;

    typedef struct packed {
        logic [SITE_W-1:0] neighbor_index;
        logic              invalid;
    } result_t;

    typedef struct packed {
        logic [LEX_W-1:0] lex;
        logic             upper;
        logic [1:0]       direction;
        logic             backward;
        logic             invalid;
    } dec_t;

    typedef struct packed {
        dec_t                           base;
        logic [MAX_AXES:0][LEX_W-1:0]   quot;
    } quo_t;

    typedef struct packed {
        logic [LEX_W-1:0]   lex;
        logic               parity;
        logic [COORD_W-1:0] coord;
        logic [1:0]         direction;
        logic               backward;
        logic               invalid;
    } crd_t;

    function automatic longint eol_pow(input int base, input int expo);
        longint acc;
        acc = 1;
        for (int i = 0; i < expo; i++)
        begin
            acc = acc * longint'(base);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/eol_decode.sv =====
`default_nettype none

module eol_decode
    import eol_pkg::*;
#(
    parameter int DIMENSIONS  = 3,
    parameter int SIDE_LENGTH = 32
)
(
    input  request_t request,
    output dec_t     dec
);

    localparam int          WIDE_W    = 41;
    localparam longint      VOLUME    = eol_pow(SIDE_LENGTH, DIMENSIONS);
    localparam logic [WIDE_W-1:0] VOL_W  = WIDE_W'(VOLUME);
    localparam logic [WIDE_W-1:0] HALF_W = WIDE_W'(VOLUME / 2);
    localparam bit          EVEN_SIDE = (SIDE_LENGTH % 2) == 0;

    always_comb
    begin
        logic [WIDE_W-1:0] site_w;
        logic [WIDE_W-1:0] rel_w;
        logic [LEX_W-1:0]  twice;
        logic              upper;
        logic              bad_dir;
        logic              bad_site;

        site_w   = WIDE_W'(request.site_index);
        bad_dir  = {1'b0, request.direction} >= 3'(DIMENSIONS);
        bad_site = site_w >= VOL_W;

        // even volume: upper half holds odd sites; odd volume: even sites run to half
        if (EVEN_SIDE)
        begin
            upper = site_w >= HALF_W;
        end
        else
        begin
            upper = site_w > HALF_W;
        end

        rel_w = upper ? (site_w - HALF_W) : site_w;
        twice = {rel_w[SITE_W-1:0], 1'b0};

        dec.lex       = (!EVEN_SIDE && upper) ? (twice - LEX_W'(1)) : twice;
        dec.upper     = upper;
        dec.direction = request.direction;
        dec.backward  = request.backward;
        dec.invalid   = bad_dir || bad_site;
    end

endmodule

`default_nettype wire

// ===== hdl/eol_divide.sv =====
`default_nettype none

module eol_divide
    import eol_pkg::*;
#(
    parameter int DIMENSIONS  = 3,
    parameter int SIDE_LENGTH = 32
)
(
    input  dec_t dec,
    output quo_t quo
);

    localparam longint LEX_MAX = (longint'(1) << LEX_W) - 1;

    logic [MAX_AXES:0][LEX_W-1:0] quot;

    // quotient by each stride, reciprocal multiply exact over the index range
    for (genvar i = 0; i <= MAX_AXES; i++)
    begin : g_quot
        if (i <= DIMENSIONS)
        begin : g_used
            localparam longint DIVISOR = eol_pow(SIDE_LENGTH, i);
            if (DIVISOR > LEX_MAX)
            begin : g_zero
                assign quot[i] = '0;
            end
            else
            begin : g_mul
                localparam int     SHIFT  = LEX_W + $clog2(DIVISOR);
                localparam longint MULT   = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
                localparam int     PROD_W = 2 * LEX_W + 2;
                logic [PROD_W-1:0] product;
                assign product = PROD_W'(dec.lex) * PROD_W'(MULT);
                assign quot[i] = LEX_W'(product >> SHIFT);
            end
        end
        else
        begin : g_unused
            assign quot[i] = '0;
        end
    end

    assign quo.base = dec;
    assign quo.quot = quot;

endmodule

`default_nettype wire

// ===== hdl/eol_coord.sv =====
`default_nettype none

module eol_coord
    import eol_pkg::*;
#(
    parameter int DIMENSIONS  = 3,
    parameter int SIDE_LENGTH = 32
)
(
    input  quo_t quo,
    output crd_t crd
);

    localparam bit   EVEN_SIDE = (SIDE_LENGTH % 2) == 0;
    localparam int   SIDE_BITS = COORD_W + 1;
    localparam int   SCALE_W   = LEX_W + SIDE_BITS;
    localparam logic [SIDE_BITS-1:0] SIDE_W = SIDE_BITS'(SIDE_LENGTH);

    always_comb
    begin
        logic               low_parity;
        logic               inc;
        logic               parity;
        logic [LEX_W-1:0]   lex;
        logic [LEX_W-1:0]   q_lo;
        logic [LEX_W-1:0]   q_hi;
        logic [LEX_W-1:0]   diff;
        logic [SCALE_W-1:0] scaled;

        // with an even side, coordinate parity is the xor of quotient lsbs
        low_parity = 1'b0;
        for (int i = 0; i < MAX_AXES; i++)
        begin
            if (i < DIMENSIONS)
            begin
                low_parity = low_parity ^ quo.quot[i][0];
            end
        end

        if (EVEN_SIDE)
        begin
            inc    = low_parity != quo.base.upper;
            parity = quo.base.upper;
        end
        else
        begin
            inc    = 1'b0;
            parity = quo.base.lex[0];
        end

        // the +1 never crosses a stride boundary, so higher quotients hold
        lex = quo.base.lex + LEX_W'(inc);

        q_lo = '0;
        q_hi = '0;
        for (int i = 0; i < MAX_AXES; i++)
        begin
            if (i < DIMENSIONS && quo.base.direction == 2'(i))
            begin
                q_lo = (i == 0) ? lex : quo.quot[i];
                q_hi = quo.quot[i+1];
            end
        end

        scaled = SCALE_W'(q_hi) * SCALE_W'(SIDE_W);
        diff   = q_lo - scaled[LEX_W-1:0];

        crd.lex       = lex;
        crd.parity    = parity;
        crd.coord     = diff[COORD_W-1:0];
        crd.direction = quo.base.direction;
        crd.backward  = quo.base.backward;
        crd.invalid   = quo.base.invalid;
    end

endmodule

`default_nettype wire

// ===== hdl/eol_step.sv =====
`default_nettype none

module eol_step
    import eol_pkg::*;
#(
    parameter int DIMENSIONS  = 3,
    parameter int SIDE_LENGTH = 32
)
(
    input  crd_t    crd,
    output result_t result
);

    localparam int              CW        = $clog2(SIDE_LENGTH);
    localparam logic [CW-1:0]   LAST      = CW'(SIDE_LENGTH - 1);
    localparam bit              EVEN_SIDE = (SIDE_LENGTH % 2) == 0;
    localparam logic [LEX_W-1:0] VOL_LO   = LEX_W'(eol_pow(SIDE_LENGTH, DIMENSIONS));

    logic [MAX_AXES-1:0][LEX_W-1:0] p_tab;
    logic [MAX_AXES-1:0][LEX_W-1:0] w_tab;

    // stride and full-wrap offset per axis, modulo the index width
    for (genvar i = 0; i < MAX_AXES; i++)
    begin : g_tab
        if (i < DIMENSIONS)
        begin : g_used
            localparam longint STRIDE = eol_pow(SIDE_LENGTH, i);
            assign p_tab[i] = LEX_W'(STRIDE);
            assign w_tab[i] = LEX_W'(STRIDE * longint'(SIDE_LENGTH - 1));
        end
        else
        begin : g_unused
            assign p_tab[i] = '0;
            assign w_tab[i] = '0;
        end
    end

    always_comb
    begin
        logic [CW-1:0]    coord;
        logic [LEX_W-1:0] stride;
        logic [LEX_W-1:0] span;
        logic [LEX_W-1:0] delta;
        logic [LEX_W-1:0] sum;
        logic             wrap;
        logic             new_parity;

        coord  = crd.coord[CW-1:0];
        stride = '0;
        span   = '0;
        for (int i = 0; i < MAX_AXES; i++)
        begin
            if (crd.direction == 2'(i))
            begin
                stride = p_tab[i];
                span   = w_tab[i];
            end
        end

        if (crd.backward)
        begin
            wrap  = coord == '0;
            delta = wrap ? span : (LEX_W'(0) - stride);
        end
        else
        begin
            wrap  = coord == LAST;
            delta = wrap ? (LEX_W'(0) - span) : stride;
        end

        // a wrap moves the coordinate by side-1, which flips parity only for an even side
        new_parity = crd.parity ^ (wrap ? EVEN_SIDE : 1'b1);
        sum        = crd.lex + delta + (new_parity ? VOL_LO : LEX_W'(0));

        result.neighbor_index = crd.invalid ? '0 : sum[LEX_W-1:1];
        result.invalid        = crd.invalid;
    end

endmodule

`default_nettype wire

// ===== hdl/even_odd_lattice_neighbor_core.sv =====
// data path: an item passes the in, dec, quo, crd and result registers in that order
// throughput: one item per cycle, each of the five register stages takes a new item every cycle
// busy stays low; the receiver cannot stall, each result shows for one cycle
// reset: rst_n async active low, clears the stage valid bits and done
`default_nettype none

module even_odd_lattice_neighbor_core
    import eol_pkg::*;
#(
    parameter int DIMENSIONS  = 3,
    parameter int SIDE_LENGTH = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    output result_t       result,
    output logic          done
);

    localparam int STAGES = 4;

    logic              accept;
    logic [STAGES-1:0] stage_valid_reg;
    logic [STAGES-1:0] stage_valid_next;
    logic              done_reg;
    logic              done_next;

    request_t in_reg;
    request_t in_next;
    dec_t     dec_reg;
    dec_t     dec_next;
    quo_t     quo_reg;
    quo_t     quo_next;
    crd_t     crd_reg;
    crd_t     crd_next;
    result_t  result_reg;
    result_t  result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_next          = request;
    assign stage_valid_next = {stage_valid_reg[STAGES-2:0], accept};
    assign done_next        = stage_valid_reg[STAGES-1];

    eol_decode #(
        .DIMENSIONS  (DIMENSIONS),
        .SIDE_LENGTH (SIDE_LENGTH)
    ) u_decode (
        .request (in_reg),
        .dec     (dec_next)
    );

    eol_divide #(
        .DIMENSIONS  (DIMENSIONS),
        .SIDE_LENGTH (SIDE_LENGTH)
    ) u_divide (
        .dec (dec_reg),
        .quo (quo_next)
    );

    eol_coord #(
        .DIMENSIONS  (DIMENSIONS),
        .SIDE_LENGTH (SIDE_LENGTH)
    ) u_coord (
        .quo (quo_reg),
        .crd (crd_next)
    );

    eol_step #(
        .DIMENSIONS  (DIMENSIONS),
        .SIDE_LENGTH (SIDE_LENGTH)
    ) u_step (
        .crd    (crd_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        dec_reg    <= dec_next;
        quo_reg    <= quo_next;
        crd_reg    <= crd_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

`ifndef NO_ASSERTIONS
    a_done_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result strobe without an item five cycles before");

    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("item taken but no result five cycles later");

    a_valid_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.invalid) |-> ({1'b0, $past(request.direction, 5)} < 3'(DIMENSIONS)))
        else $error("valid result for an axis beyond the dimension count");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.invalid) |-> (result.neighbor_index == '0))
        else $error("invalid result with nonzero index");
`endif

endmodule

`default_nettype wire
